// ===== hdl/lacu_pkg.sv =====
// Shared types and constants for the limit alarm counter unit.
package lacu_pkg;

  localparam logic [1:0] CMD_CHECK = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam int HIT_ALARM_LOW  = 0;
  localparam int HIT_ALARM_HIGH = 1;
  localparam int HIT_WARN_LOW   = 2;
  localparam int HIT_WARN_HIGH  = 3;
  localparam int HIT_BITS       = 4;

  localparam int CMD_BITS    = 2;
  localparam int IDX_BITS    = 6;
  localparam int DATA_BITS   = 32;
  localparam int OUT_BITS    = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;

  typedef logic signed [DATA_BITS-1:0] q16_t;
  typedef logic [OUT_BITS-1:0] count_out_t;

  typedef struct packed {
    logic [CMD_BITS-1:0] op;
    logic [IDX_BITS-1:0] idx;
    logic                row_ok;
    logic [HIT_BITS-1:0] mask;
    logic                close_shot;
    logic                alarm_shot;
    logic                warn_shot;
  } lacu_item_t;

endpackage

// ===== hdl/lacu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lacu_ram #(
  parameter int WIDTH     = 8,
  parameter int DEPTH     = 16,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/lacu_front.sv =====
// Front end: accepts items, compares against the limits and tracks per-shot flags.
module lacu_front #(
  parameter int PARAM_COUNT = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic                                 cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [lacu_pkg::CMD_BITS-1:0]        in_cmd,
  input  logic [lacu_pkg::IDX_BITS-1:0]        in_param_index,
  input  lacu_pkg::q16_t                       in_sample_value,
  input  lacu_pkg::q16_t                       in_alarm_low,
  input  lacu_pkg::q16_t                       in_alarm_high,
  input  lacu_pkg::q16_t                       in_warn_low,
  input  lacu_pkg::q16_t                       in_warn_high,
  input  logic                                 in_is_external,
  input  logic                                 in_last_in_shot,
  input  logic                                 q_full,
  output logic                                 q_push,
  output lacu_pkg::lacu_item_t                 q_item
);

  import lacu_pkg::*;

  localparam int IDX_RANGE = 1 << IDX_BITS;
  localparam int ROW_LIMIT = (PARAM_COUNT > IDX_RANGE) ? IDX_RANGE : PARAM_COUNT;
  localparam logic [IDX_BITS:0] ROW_LIMIT_V = (IDX_BITS + 1)'(ROW_LIMIT);

  logic                check_ext_r;
  logic                skip_r, skip_nxt;
  logic                shot_alarm_r, shot_alarm_nxt;
  logic                shot_warn_r, shot_warn_nxt;
  logic                fire;
  logic                skip_now;
  logic                alarm_any, warn_any;
  logic [CMD_BITS-1:0] op;
  logic [HIT_BITS-1:0] raw_mask, mask;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign q_push   = fire;

  always_comb begin
    unique case (in_cmd)
      CMD_CHECK: op = CMD_CHECK;
      CMD_CLEAR: op = CMD_CLEAR;
      default:   op = CMD_READ;
    endcase
  end

  assign skip_now = skip_r | (~check_ext_r & in_is_external);

  always_comb begin
    raw_mask = '0;
    if (in_alarm_low != in_alarm_high) begin
      raw_mask[HIT_ALARM_LOW]  = in_sample_value < in_alarm_low;
      raw_mask[HIT_ALARM_HIGH] = in_sample_value > in_alarm_high;
    end
    if (in_warn_low != in_warn_high) begin
      raw_mask[HIT_WARN_LOW]  = in_sample_value < in_warn_low;
      raw_mask[HIT_WARN_HIGH] = in_sample_value > in_warn_high;
    end
  end

  assign mask      = (op == CMD_CHECK && !skip_now) ? raw_mask : '0;
  assign alarm_any = mask[HIT_ALARM_LOW] | mask[HIT_ALARM_HIGH];
  assign warn_any  = mask[HIT_WARN_LOW] | mask[HIT_WARN_HIGH];

  always_comb begin
    q_item.op         = op;
    q_item.idx        = in_param_index;
    q_item.row_ok     = {1'b0, in_param_index} < ROW_LIMIT_V;
    q_item.mask       = mask;
    q_item.close_shot = (op == CMD_CHECK) && in_last_in_shot;
    q_item.alarm_shot = q_item.close_shot && (shot_alarm_r || alarm_any);
    q_item.warn_shot  = q_item.close_shot && (shot_warn_r || warn_any);
  end

  always_comb begin
    skip_nxt       = skip_r;
    shot_alarm_nxt = shot_alarm_r;
    shot_warn_nxt  = shot_warn_r;
    if (fire) begin
      if (op == CMD_CLEAR) begin
        skip_nxt       = 1'b0;
        shot_alarm_nxt = 1'b0;
        shot_warn_nxt  = 1'b0;
      end else if (op == CMD_CHECK) begin
        if (in_last_in_shot) begin
          skip_nxt       = 1'b0;
          shot_alarm_nxt = 1'b0;
          shot_warn_nxt  = 1'b0;
        end else begin
          skip_nxt       = skip_now;
          shot_alarm_nxt = shot_alarm_r | alarm_any;
          shot_warn_nxt  = shot_warn_r | warn_any;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_ext_r  <= 1'b0;
      skip_r       <= 1'b0;
      shot_alarm_r <= 1'b0;
      shot_warn_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        check_ext_r <= cfg_wdata;
      end
      skip_r       <= skip_nxt;
      shot_alarm_r <= shot_alarm_nxt;
      shot_warn_r  <= shot_warn_nxt;
    end
  end

`ifndef SYNTH
  a_shot_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && op == CMD_CHECK && in_last_in_shot |=> !skip_r && !shot_alarm_r && !shot_warn_r)
    else $error("shot flags not cleared after the closing item");
`endif

endmodule

// ===== hdl/lacu_queue.sv =====
// Short queue of classified items between the front end and the count engine.
module lacu_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lacu_pkg::lacu_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output lacu_pkg::lacu_item_t pop_item,
  output logic                 not_empty
);

  import lacu_pkg::*;

  localparam logic [QPTR_BITS:0] DEPTH_V = (QPTR_BITS + 1)'(QUEUE_DEPTH);

  lacu_item_t           entries_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_BITS:0]   count_r, count_nxt;

  assign full      = count_r == DEPTH_V;
  assign not_empty = count_r != '0;
  assign pop_item  = entries_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from an empty queue");
`endif

endmodule

// ===== hdl/lacu_back.sv =====
// Count engine: row read-modify-write with forwarding, shot totals and result register.
module lacu_back #(
  parameter int PARAM_COUNT = 64,
  parameter int COUNT_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_not_empty,
  input  lacu_pkg::lacu_item_t          q_item,
  output logic                          q_pop,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [lacu_pkg::HIT_BITS-1:0] out_hit_mask,
  output lacu_pkg::count_out_t          out_low_alarm_count,
  output lacu_pkg::count_out_t          out_high_alarm_count,
  output lacu_pkg::count_out_t          out_low_warn_count,
  output lacu_pkg::count_out_t          out_high_warn_count,
  output lacu_pkg::count_out_t          out_shots_seen,
  output lacu_pkg::count_out_t          out_alarm_shots,
  output lacu_pkg::count_out_t          out_warning_shots
);

  import lacu_pkg::*;

  localparam int IDX_RANGE = 1 << IDX_BITS;
  localparam int ROWS      = (PARAM_COUNT > IDX_RANGE) ? IDX_RANGE : PARAM_COUNT;
  localparam int ADDR_BITS = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROW_BITS  = HIT_BITS * COUNT_BITS;

  logic                  s1_valid_r;
  lacu_item_t            s1_item_r;
  logic                  out_valid_r;
  logic [HIT_BITS-1:0]   hit_mask_r;
  count_out_t            row_out_r [HIT_BITS];
  logic [ROWS-1:0]       row_valid_r;
  logic                  fwd_valid_r;
  logic [ADDR_BITS-1:0]  fwd_addr_r;
  logic [ROW_BITS-1:0]   fwd_data_r;
  logic [COUNT_BITS-1:0] shots_r, shots_nxt;
  logic [COUNT_BITS-1:0] alarm_shots_r, alarm_shots_nxt;
  logic [COUNT_BITS-1:0] warn_shots_r, warn_shots_nxt;

  logic                  out_free, s1_fire, s1_adv;
  logic                  is_check, is_clear, wr_en;
  logic [ADDR_BITS-1:0]  rd_addr, s1_addr;
  logic [ROW_BITS-1:0]   rd_data, old_row, new_row;
  logic [COUNT_BITS-1:0] cnt_old [HIT_BITS];
  logic [COUNT_BITS-1:0] cnt_new [HIT_BITS];

  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign s1_adv   = !s1_valid_r || out_free;
  assign q_pop    = q_not_empty && s1_adv;

  assign rd_addr  = q_item.idx[ADDR_BITS-1:0];
  assign s1_addr  = s1_item_r.idx[ADDR_BITS-1:0];
  assign is_check = s1_item_r.op == CMD_CHECK;
  assign is_clear = s1_item_r.op == CMD_CLEAR;
  assign wr_en    = s1_fire && is_check && s1_item_r.row_ok && (s1_item_r.mask != '0);

  lacu_ram #(
    .WIDTH     (ROW_BITS),
    .DEPTH     (ROWS),
    .ADDR_BITS (ADDR_BITS)
  ) u_count_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (new_row),
    .re    (q_pop),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    if (fwd_valid_r && fwd_addr_r == s1_addr) begin
      old_row = fwd_data_r;
    end else if (s1_item_r.row_ok && row_valid_r[s1_addr]) begin
      old_row = rd_data;
    end else begin
      old_row = '0;
    end
    for (int k = 0; k < HIT_BITS; k++) begin
      cnt_old[k] = old_row[k*COUNT_BITS +: COUNT_BITS];
      if (is_check && s1_item_r.mask[k] && cnt_old[k] != '1) begin
        cnt_new[k] = cnt_old[k] + 1'b1;
      end else begin
        cnt_new[k] = cnt_old[k];
      end
      new_row[k*COUNT_BITS +: COUNT_BITS] = cnt_new[k];
    end
  end

  always_comb begin
    shots_nxt       = shots_r;
    alarm_shots_nxt = alarm_shots_r;
    warn_shots_nxt  = warn_shots_r;
    if (is_clear) begin
      shots_nxt       = '0;
      alarm_shots_nxt = '0;
      warn_shots_nxt  = '0;
    end else if (s1_item_r.close_shot) begin
      if (shots_r != '1) begin
        shots_nxt = shots_r + 1'b1;
      end
      if (s1_item_r.alarm_shot && alarm_shots_r != '1) begin
        alarm_shots_nxt = alarm_shots_r + 1'b1;
      end
      if (s1_item_r.warn_shot && warn_shots_r != '1) begin
        warn_shots_nxt = warn_shots_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_item_r <= q_item;
    end
    if (s1_fire) begin
      hit_mask_r <= s1_item_r.mask;
      for (int k = 0; k < HIT_BITS; k++) begin
        row_out_r[k] <= (s1_item_r.row_ok && !is_clear) ? OUT_BITS'(cnt_new[k]) : '0;
      end
    end
    if (wr_en) begin
      fwd_addr_r <= s1_addr;
      fwd_data_r <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      row_valid_r   <= '0;
      fwd_valid_r   <= 1'b0;
      shots_r       <= '0;
      alarm_shots_r <= '0;
      warn_shots_r  <= '0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= q_not_empty;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        shots_r       <= shots_nxt;
        alarm_shots_r <= alarm_shots_nxt;
        warn_shots_r  <= warn_shots_nxt;
      end
      if (s1_fire && is_clear) begin
        row_valid_r <= '0;
        fwd_valid_r <= 1'b0;
      end else if (wr_en) begin
        row_valid_r[s1_addr] <= 1'b1;
        fwd_valid_r          <= 1'b1;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hit_mask         = hit_mask_r;
  assign out_low_alarm_count  = row_out_r[HIT_ALARM_LOW];
  assign out_high_alarm_count = row_out_r[HIT_ALARM_HIGH];
  assign out_low_warn_count   = row_out_r[HIT_WARN_LOW];
  assign out_high_warn_count  = row_out_r[HIT_WARN_HIGH];
  assign out_shots_seen       = OUT_BITS'(shots_r);
  assign out_alarm_shots      = OUT_BITS'(alarm_shots_r);
  assign out_warning_shots    = OUT_BITS'(warn_shots_r);

`ifndef SYNTH
  a_alarm_le_shots: assert property (@(posedge clk) disable iff (!rst_n)
    alarm_shots_r <= shots_r)
    else $error("alarmed shots exceed shots seen");
  a_warn_le_shots: assert property (@(posedge clk) disable iff (!rst_n)
    warn_shots_r <= shots_r)
    else $error("warned shots exceed shots seen");
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && is_clear |=> shots_r == '0 && row_valid_r == '0 && !fwd_valid_r)
    else $error("clear left counts behind");
`endif

endmodule

// ===== hdl/limit_alarm_counter_unit.sv =====
// Top level of the limit alarm counter unit.
//
// Items arrive on the in_ channel (valid/ready). A check item compares its
// sample against an alarm and a warning window, counts each hit in the row of
// its parameter and closes the shot on its last item. A read item returns a
// row, and a clear item zeroes every count and the shot totals.
// Every accepted item produces exactly one transfer on the out_ channel, in
// order, with the row counts and shot totals after the update.
// The block takes one item per cycle while the queue is not full. The count
// memory is read when an item leaves the queue and written when the item
// leaves s1 for the result register, with the last written row forwarded.
// A four-entry queue separates intake from the count engine, so in_ready
// depends only on queue occupancy; when out_ready stays low the queue fills
// and in_ready drops.
// cfg_we writes check_external from cfg_wdata; write it only while idle.
// Synchronous reset clears all counts, totals, shot flags and check_external;
// the count rows are cleared by per-row valid bits, with no sweep.
module limit_alarm_counter_unit #(
  parameter int PARAM_COUNT = 64,
  parameter int COUNT_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lacu_pkg::CMD_BITS-1:0] in_cmd,
  input  logic [lacu_pkg::IDX_BITS-1:0] in_param_index,
  input  lacu_pkg::q16_t                in_sample_value,
  input  lacu_pkg::q16_t                in_alarm_low,
  input  lacu_pkg::q16_t                in_alarm_high,
  input  lacu_pkg::q16_t                in_warn_low,
  input  lacu_pkg::q16_t                in_warn_high,
  input  logic                          in_is_external,
  input  logic                          in_last_in_shot,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lacu_pkg::HIT_BITS-1:0] out_hit_mask,
  output lacu_pkg::count_out_t          out_low_alarm_count,
  output lacu_pkg::count_out_t          out_high_alarm_count,
  output lacu_pkg::count_out_t          out_low_warn_count,
  output lacu_pkg::count_out_t          out_high_warn_count,
  output lacu_pkg::count_out_t          out_shots_seen,
  output lacu_pkg::count_out_t          out_alarm_shots,
  output lacu_pkg::count_out_t          out_warning_shots
);

  import lacu_pkg::*;

  logic       q_full, q_push, q_pop, q_not_empty;
  lacu_item_t q_push_item, q_pop_item;

  lacu_front #(
    .PARAM_COUNT (PARAM_COUNT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_param_index  (in_param_index),
    .in_sample_value (in_sample_value),
    .in_alarm_low    (in_alarm_low),
    .in_alarm_high   (in_alarm_high),
    .in_warn_low     (in_warn_low),
    .in_warn_high    (in_warn_high),
    .in_is_external  (in_is_external),
    .in_last_in_shot (in_last_in_shot),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (q_push_item)
  );

  lacu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_pop_item),
    .not_empty (q_not_empty)
  );

  lacu_back #(
    .PARAM_COUNT (PARAM_COUNT),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_not_empty          (q_not_empty),
    .q_item               (q_pop_item),
    .q_pop                (q_pop),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_hit_mask         (out_hit_mask),
    .out_low_alarm_count  (out_low_alarm_count),
    .out_high_alarm_count (out_high_alarm_count),
    .out_low_warn_count   (out_low_warn_count),
    .out_high_warn_count  (out_high_warn_count),
    .out_shots_seen       (out_shots_seen),
    .out_alarm_shots      (out_alarm_shots),
    .out_warning_shots    (out_warning_shots)
  );

endmodule
